@@ rtl/bsa_pkg.sv @@
package bsa_pkg;

    localparam int MAX_SLOTS = 1024;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int LIMIT_W   = 11;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int WORD_BITS  = (MAX_SLOTS >= 64) ? 32 : MAX_SLOTS / 2;
    localparam int NUM_WORDS  = MAX_SLOTS / WORD_BITS;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = SLOT_W - BIT_W;
    localparam int LIM_W      = $clog2(MAX_SLOTS + 1);

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_POOL_BASE  = 2'd0,
        REG_SLOT_BYTES = 2'd1,
        REG_SLOT_LIMIT = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        logic load_req;
        logic scan_first;
        logic scan_step;
        logic alloc_commit;
        logic mul_slot;
        logic set_full;
        logic div_start;
        logic set_bad;
        logic free_read;
        logic free_commit;
        logic emit;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_free;
        logic below_base;
        logic scan_hit;
        logic scan_last;
        logic div_done;
        logic idx_over;
        logic slot_used;
        logic out_free;
    } dp_sts_t;

endpackage

@@ rtl/bsa_req_if.sv @@
interface bsa_req_if
    import bsa_pkg::*;
    ();

    logic               valid;
    logic               ready;
    func_t              func;
    logic [ADDR_W-1:0]  release_address;

    modport source
    (
        output valid,
        output func,
        output release_address,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  release_address,
        output ready
    );

endinterface

@@ rtl/bsa_rsp_if.sv @@
interface bsa_rsp_if
    import bsa_pkg::*;
    ();

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  slot_address;
    status_t            status;
    logic [COUNT_W-1:0] in_use;

    modport source
    (
        output valid,
        output slot_address,
        output status,
        output in_use,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  slot_address,
        input  status,
        input  in_use,
        output ready
    );

endinterface

@@ rtl/bitmap_slot_allocator.sv @@
// Fixed-size slot allocator over a pool of MAX_SLOTS slots with one used bit per slot.
// An allocate transaction returns pool_base + slot * slot_bytes for the lowest free slot
// below slot_limit, or status full; a free transaction divides (address - pool_base) by
// slot_bytes and clears that slot, flagging an address below the base, past the limit or
// not in use with status bad free and changing nothing. One transaction is worked at a
// time and each gives one result. The map sits in a word memory with one read and one
// write port, read one word per cycle; an allocate reads the 32-slot map words in order,
// one to 32 of them, until a free slot or the limit is reached. A free divides with a
// divider that yields one quotient bit per cycle; a free whose index is past the limit
// is flagged once the division ends, and one below the base with no division. A result
// waits while the output register stays full. Per-word valid flags are cleared by reset,
// so the map is empty at once with no clearing pass. A new request is taken while the
// previous result still waits in the output register.
module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bsa_req_if.sink               req,
    bsa_rsp_if.source             rsp
);

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic               ready_w;
    logic               rsp_valid_w;
    logic [ADDR_W-1:0]  rsp_addr_w;
    status_t            rsp_status_w;
    logic [COUNT_W-1:0] rsp_in_use_w;

    bsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready_w),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsa_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_func         (req.func),
        .req_address      (req.release_address),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp_valid_w),
        .rsp_slot_address (rsp_addr_w),
        .rsp_status       (rsp_status_w),
        .rsp_in_use       (rsp_in_use_w),
        .cmd              (cmd),
        .sts              (sts)
    );

    assign req.ready        = ready_w;
    assign rsp.valid        = rsp_valid_w;
    assign rsp.slot_address = rsp_addr_w;
    assign rsp.status       = rsp_status_w;
    assign rsp.in_use       = rsp_in_use_w;

`ifndef ASSERT_OFF
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an unaccepted result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken while one is in progress");

    a_alloc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> !sts.is_free)
        else $error("slot marked used on a free request");

    a_free_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_commit |-> (sts.is_free && !sts.idx_over))
        else $error("slot cleared outside a valid free request");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("result lost after load");
`endif

endmodule

@@ rtl/bsa_ram.sv @@
module bsa_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bsa_div.sv @@
module bsa_div
    import bsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic [ADDR_W-1:0] quotient,
    output logic              busy
);

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] quo_reg;
    logic [ADDR_W-1:0] quo_next;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [SIZE_W-1:0] dsr_reg;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W+1:0] diff;
    logic              borrow;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ADDR_W-1]};
        diff     = {1'b0, trial} - {2'b00, dsr_reg};
        borrow   = diff[SIZE_W+1];
        rem_next = borrow ? trial[SIZE_W-1:0] : diff[SIZE_W-1:0];
        quo_next = {quo_reg[ADDR_W-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ADDR_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

@@ rtl/bsa_datapath.sv @@
module bsa_datapath
    import bsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  func_t                 req_func,
    input  logic [ADDR_W-1:0]     req_address,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output logic [ADDR_W-1:0]     rsp_slot_address,
    output status_t               rsp_status,
    output logic [COUNT_W-1:0]    rsp_in_use,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    localparam int EXT_W  = LIM_W + 1;
    localparam int PROD_W = SLOT_W + SIZE_W;

    logic [ADDR_W-1:0]     base_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    func_t                 func_reg;
    logic [ADDR_W-1:0]     addr_reg;
    status_t               res_status_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [ADDR_W-1:0]     prod_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [WORD_IDX_W:0]   rd_word_reg;
    logic [WORD_IDX_W-1:0] chk_word_reg;
    logic [NUM_WORDS-1:0]  vld_reg;
    logic                  rd_vld_reg;

    logic                  rsp_valid_reg;
    logic [ADDR_W-1:0]     rsp_addr_reg;
    status_t               rsp_status_reg;
    logic [COUNT_W-1:0]    rsp_in_use_reg;

    logic [SIZE_W-1:0]     eff_size;
    logic [LIM_W-1:0]      lim;
    logic [EXT_W-1:0]      lim_ext;
    logic [EXT_W-1:0]      word_lo;
    logic [EXT_W-1:0]      word_hi;
    logic [EXT_W-1:0]      lim_rem;
    logic [WORD_BITS-1:0]  avail;
    logic [WORD_BITS-1:0]  free_bits;
    logic [BIT_W-1:0]      free_pos;
    logic [WORD_BITS-1:0]  ram_q;
    logic [WORD_BITS-1:0]  word_q;

    logic                  ram_re;
    logic [WORD_IDX_W-1:0] ram_raddr;
    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;

    logic [ADDR_W-1:0]     quotient;
    logic                  div_busy;
    logic [WORD_IDX_W-1:0] free_word;
    logic [BIT_W-1:0]      free_bit;
    logic [PROD_W-1:0]     prod_full;
    logic [ADDR_W-1:0]     rsp_addr_next;

    assign eff_size  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign lim       = (32'(limit_reg) > 32'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS)
                                                         : LIM_W'(limit_reg);
    assign lim_ext   = EXT_W'(lim);
    assign free_word = quotient[SLOT_W-1:BIT_W];
    assign free_bit  = quotient[BIT_W-1:0];
    assign word_q    = rd_vld_reg ? ram_q : '0;

    // mask off slots at or past the slot limit
    always_comb
    begin
        word_lo = EXT_W'({chk_word_reg, {BIT_W{1'b0}}});
        word_hi = word_lo + EXT_W'(WORD_BITS);
        lim_rem = lim_ext - word_lo;
        if (lim_ext >= word_hi)
        begin
            avail = '1;
        end
        else if (lim_ext <= word_lo)
        begin
            avail = '0;
        end
        else
        begin
            avail = ~({WORD_BITS{1'b1}} << lim_rem[BIT_W-1:0]);
        end
        free_bits = ~word_q & avail;
    end

    always_comb
    begin
        free_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                free_pos = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        ram_re = cmd.scan_first | cmd.scan_step | cmd.free_read;
        priority if (cmd.scan_step)
        begin
            ram_raddr = rd_word_reg[WORD_IDX_W-1:0];
        end
        else if (cmd.free_read)
        begin
            ram_raddr = free_word;
        end
        else
        begin
            ram_raddr = '0;
        end

        ram_we = cmd.alloc_commit | cmd.free_commit;
        if (cmd.alloc_commit)
        begin
            ram_waddr = chk_word_reg;
            ram_wdata = word_q | (WORD_BITS'(1) << free_pos);
        end
        else
        begin
            ram_waddr = free_word;
            ram_wdata = word_q & ~(WORD_BITS'(1) << free_bit);
        end
    end

    bsa_ram
    #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    )
    u_map
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    bsa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (addr_reg - base_reg),
        .divisor  (eff_size),
        .quotient (quotient),
        .busy     (div_busy)
    );

    assign prod_full     = PROD_W'(slot_reg) * PROD_W'(eff_size);
    assign rsp_addr_next = (res_status_reg == STATUS_OK && func_reg == FUNC_ALLOC)
                         ? base_reg + prod_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            size_reg      <= SIZE_W'(1);
            limit_reg     <= '0;
            count_reg     <= '0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_POOL_BASE:  base_reg  <= cfg_data[ADDR_W-1:0];
                    REG_SLOT_BYTES: size_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SLOT_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.alloc_commit)
            begin
                count_reg              <= count_reg + COUNT_W'(1);
                vld_reg[chk_word_reg]  <= 1'b1;
            end
            else if (cmd.free_commit)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= req_func;
            addr_reg <= req_address;
        end
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
        if (cmd.scan_first)
        begin
            rd_word_reg  <= (WORD_IDX_W + 1)'(1);
            chk_word_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            rd_word_reg  <= rd_word_reg + (WORD_IDX_W + 1)'(1);
            chk_word_reg <= rd_word_reg[WORD_IDX_W-1:0];
        end
        if (cmd.alloc_commit)
        begin
            slot_reg <= {chk_word_reg, free_pos};
        end
        if (cmd.mul_slot)
        begin
            prod_reg <= ADDR_W'(prod_full);
        end
        if (cmd.alloc_commit || cmd.free_commit)
        begin
            res_status_reg <= STATUS_OK;
        end
        else if (cmd.set_full)
        begin
            res_status_reg <= STATUS_FULL;
        end
        else if (cmd.set_bad)
        begin
            res_status_reg <= STATUS_BAD_FREE;
        end
        if (cmd.emit)
        begin
            rsp_addr_reg   <= rsp_addr_next;
            rsp_status_reg <= res_status_reg;
            rsp_in_use_reg <= count_reg;
        end
    end

    always_comb
    begin
        sts.is_free    = (func_reg == FUNC_FREE);
        sts.below_base = (addr_reg < base_reg);
        sts.scan_hit   = |free_bits;
        sts.scan_last  = ~(|free_bits) && (lim_ext <= word_hi);
        sts.div_done   = ~div_busy;
        sts.idx_over   = (quotient >= ADDR_W'(lim));
        sts.slot_used  = word_q[free_bit];
        sts.out_free   = ~rsp_valid_reg | rsp_ready;
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_slot_address = rsp_addr_reg;
    assign rsp_status       = rsp_status_reg;
    assign rsp_in_use       = rsp_in_use_reg;

endmodule

@@ rtl/bsa_ctrl.sv @@
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MUL,
        S_DIVIDE,
        S_FREE_TEST,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (!sts.is_free)
                begin
                    cmd.scan_first = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.below_base)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
            end
            S_SCAN:
            begin
                priority if (sts.scan_hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_MUL;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul_slot = 1'b1;
                state_next   = S_EMIT;
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    if (sts.idx_over)
                    begin
                        cmd.set_bad = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        cmd.free_read = 1'b1;
                        state_next    = S_FREE_TEST;
                    end
                end
            end
            S_FREE_TEST:
            begin
                if (sts.slot_used)
                begin
                    cmd.free_commit = 1'b1;
                end
                else
                begin
                    cmd.set_bad = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
